### rtl/rfab_pkg.sv
// ----------------------------------------------------------------------------
// rfab_pkg: shared types and constants for the rectangle fill blender
// Field widths, command codes, register indexes and the RGBA pixel type.
// ----------------------------------------------------------------------------
package rfab_pkg;

  // Field widths fixed by the command format
  localparam int COORD_W     = 16;
  localparam int CHAN_W      = 8;
  localparam int REG_W       = 9;
  localparam int CFG_INDEX_W = 1;
  localparam int OP_W        = 2;

  // Store geometry defaults and canvas size after reset
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int CANVAS_RESET   = 256;

  // Command codes
  localparam logic [OP_W-1:0] OP_FILL  = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_CANVAS_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CANVAS_HEIGHT = 1'b1;

  // One RGBA8 pixel, red in the top byte
  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } color_t;

  localparam color_t COLOR_BLANK = '0;

endpackage

### rtl/rfab_store.sv
// ----------------------------------------------------------------------------
// rfab_store: pixel memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module rfab_store
  import rfab_pkg::*;
#(
  parameter int ADDR_W = 16
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  color_t            wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output color_t            rd_data
);

  localparam int DEPTH = 2 ** ADDR_W;

  color_t mem [DEPTH];

  // Write one pixel
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read one pixel, data valid the next cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/rfab_blend.sv
// ----------------------------------------------------------------------------
// rfab_blend: straight-alpha over unit
// Two-stage pipeline, one pixel per cycle: products, then sum and round /255.
// ----------------------------------------------------------------------------
module rfab_blend
  import rfab_pkg::*;
#(
  parameter int ADDR_W = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [ADDR_W-1:0] in_addr,
  input  color_t            dst,
  input  color_t            src,
  output logic              out_valid,
  output logic [ADDR_W-1:0] out_addr,
  output color_t            out_pixel,
  output logic              active
);

  localparam int PROD_W = 2 * CHAN_W;

  // Round n/255 half up; exact for n up to 255*255
  function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W:0] n);
    logic [PROD_W:0] t;
    logic [PROD_W:0] s;
    t = n + (PROD_W+1)'(128);
    s = t + (t >> CHAN_W);
    return CHAN_W'(s >> CHAN_W);
  endfunction

  logic [CHAN_W-1:0] inv_alpha;

  logic              s1_valid;
  logic [ADDR_W-1:0] s1_addr;
  logic [CHAN_W-1:0] s1_alpha;
  logic [PROD_W-1:0] ps_red, ps_green, ps_blue;
  logic [PROD_W-1:0] pd_red, pd_green, pd_blue, pd_alpha;

  logic [CHAN_W:0]   alpha_sum;

  assign inv_alpha = CHAN_W'(8'd255 - src.alpha);

  // Stage 1: source and destination products
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
    s1_addr  <= in_addr;
    s1_alpha <= src.alpha;
    ps_red   <= PROD_W'(src.red)   * PROD_W'(src.alpha);
    ps_green <= PROD_W'(src.green) * PROD_W'(src.alpha);
    ps_blue  <= PROD_W'(src.blue)  * PROD_W'(src.alpha);
    pd_red   <= PROD_W'(dst.red)   * PROD_W'(inv_alpha);
    pd_green <= PROD_W'(dst.green) * PROD_W'(inv_alpha);
    pd_blue  <= PROD_W'(dst.blue)  * PROD_W'(inv_alpha);
    pd_alpha <= PROD_W'(dst.alpha) * PROD_W'(inv_alpha);
  end

  assign alpha_sum = (CHAN_W+1)'(s1_alpha) + (CHAN_W+1)'(div255((PROD_W+1)'(pd_alpha)));

  // Stage 2: sum, round and saturate alpha
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s1_valid;
    end
    out_addr        <= s1_addr;
    out_pixel.red   <= div255((PROD_W+1)'(ps_red)   + (PROD_W+1)'(pd_red));
    out_pixel.green <= div255((PROD_W+1)'(ps_green) + (PROD_W+1)'(pd_green));
    out_pixel.blue  <= div255((PROD_W+1)'(ps_blue)  + (PROD_W+1)'(pd_blue));
    out_pixel.alpha <= alpha_sum[CHAN_W] ? {CHAN_W{1'b1}} : alpha_sum[CHAN_W-1:0];
  end

  assign active = s1_valid | out_valid;

endmodule

### rtl/rect_fill_alpha_blend_top.sv
// ----------------------------------------------------------------------------
// rect_fill_alpha_blend_top: alpha-blended rectangle fill over an RGBA8 store
// Sequencer, clipping and canvas registers around the store and blend unit.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; busy stays high until
// it is finished, and each command gives one result beat on done, which the
// receiver must take in that cycle. In a fill the memory is read once per
// pixel of the clipped area and each pixel streams through the two-stage blend
// unit back to the write port. A clear sweeps the whole store at one entry a
// cycle. After reset the block is busy for one such sweep while it zeroes the
// store; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module rect_fill_alpha_blend_top
  import rfab_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]       cfg_data,
  input  logic                   start,
  input  logic [OP_W-1:0]        operation,
  input  logic [COORD_W-1:0]     left,
  input  logic [COORD_W-1:0]     top,
  input  logic [COORD_W-1:0]     right,
  input  logic [COORD_W-1:0]     bottom,
  input  logic [CHAN_W-1:0]      red,
  input  logic [CHAN_W-1:0]      green,
  input  logic [CHAN_W-1:0]      blue,
  input  logic [CHAN_W-1:0]      alpha,
  output logic                   busy,
  output logic                   done,
  output logic [CHAN_W-1:0]      pixel_red,
  output logic [CHAN_W-1:0]      pixel_green,
  output logic [CHAN_W-1:0]      pixel_blue,
  output logic [CHAN_W-1:0]      pixel_alpha
);

  // Coordinate counters hold up to the store size; addresses drop the top
  localparam int XCW    = $clog2(MAX_WIDTH + 1);
  localparam int YCW    = $clog2(MAX_HEIGHT + 1);
  localparam int XW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int ADDR_W = XW + YW;
  localparam int XEW    = (XCW > REG_W) ? XCW : REG_W;
  localparam int YEW    = (YCW > REG_W) ? YCW : REG_W;
  localparam int W_RST  = (CANVAS_RESET > MAX_WIDTH) ? MAX_WIDTH : CANVAS_RESET;
  localparam int H_RST  = (CANVAS_RESET > MAX_HEIGHT) ? MAX_HEIGHT : CANVAS_RESET;

  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SETUP = 3'd2;
  localparam logic [2:0] ST_FILL  = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_CLEAR = 3'd5;
  localparam logic [2:0] ST_READ  = 3'd6;

  // Clamp a signed edge to [0, lim]
  function automatic logic [COORD_W-1:0] clip_edge(input logic [COORD_W-1:0] v,
                                                    input logic [COORD_W-1:0] lim);
    if (v[COORD_W-1]) begin
      return '0;
    end else if (v > lim) begin
      return lim;
    end else begin
      return v;
    end
  endfunction

  logic [2:0]          state;
  logic [XCW-1:0]      width_eff;
  logic [YCW-1:0]      height_eff;
  logic [XEW-1:0]      cfg_w_ext;
  logic [YEW-1:0]      cfg_h_ext;

  logic [OP_W-1:0]     op_q;
  logic [COORD_W-1:0]  left_q, top_q, right_q, bottom_q;
  color_t              color_q;

  logic [ADDR_W-1:0]   clr_cnt;
  logic [XCW-1:0]      x_cnt, x0, x1;
  logic [YCW-1:0]      y_cnt, y1;
  logic [XCW-1:0]      x0c, x1c;
  logic [YCW-1:0]      y0c, y1c;
  logic [COORD_W-1:0]  w16, h16;
  logic                in_bounds, in_bounds_q;

  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr, rd_addr_q;
  logic                rd_valid;
  color_t              rd_data;

  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  color_t              wr_data;

  logic                bl_valid;
  logic [ADDR_W-1:0]   bl_addr;
  color_t              bl_pixel;
  logic                bl_active;

  color_t              pixel_q;

  // Canvas size, saturated to the store size on write
  assign cfg_w_ext = XEW'(cfg_data);
  assign cfg_h_ext = YEW'(cfg_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      width_eff  <= XCW'(W_RST);
      height_eff <= YCW'(H_RST);
    end else if (cfg_we) begin
      if (cfg_index == CFG_CANVAS_WIDTH) begin
        width_eff <= (cfg_w_ext > XEW'(MAX_WIDTH)) ? XCW'(MAX_WIDTH) : XCW'(cfg_w_ext);
      end else begin
        height_eff <= (cfg_h_ext > YEW'(MAX_HEIGHT)) ? YCW'(MAX_HEIGHT) : YCW'(cfg_h_ext);
      end
    end
  end

  // Clip the held rectangle and check the read position
  assign w16 = COORD_W'(width_eff);
  assign h16 = COORD_W'(height_eff);

  always_comb begin
    x0c       = XCW'(clip_edge(left_q, w16));
    x1c       = XCW'(clip_edge(right_q, w16));
    y0c       = YCW'(clip_edge(top_q, h16));
    y1c       = YCW'(clip_edge(bottom_q, h16));
    in_bounds = !left_q[COORD_W-1] && !top_q[COORD_W-1] && (left_q < w16) && (top_q < h16);
  end

  // Memory read port: fill sweep or single read
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = {y_cnt[YW-1:0], x_cnt[XW-1:0]};
    if (state == ST_FILL) begin
      rd_en = 1'b1;
    end else if (state == ST_SETUP && op_q == OP_READ) begin
      rd_en   = in_bounds;
      rd_addr = {top_q[YW-1:0], left_q[XW-1:0]};
    end
  end

  // Memory write port: clearing sweep or blended pixel
  always_comb begin
    if (state == ST_INIT || state == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt;
      wr_data = (state == ST_INIT) ? COLOR_BLANK : color_q;
    end else begin
      wr_en   = bl_valid;
      wr_addr = bl_addr;
      wr_data = bl_pixel;
    end
  end

  // Track fill reads into the blend unit
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= (state == ST_FILL);
    end
    rd_addr_q <= rd_addr;
  end

  // Command sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_INIT;
      clr_cnt <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_INIT: begin
          clr_cnt <= clr_cnt + ADDR_W'(1);
          if (&clr_cnt) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            state <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          // load the sweep position at the top-left corner
          x_cnt <= x0c;
          y_cnt <= y0c;
          unique case (op_q)
            OP_FILL: begin
              if (x0c < x1c && y0c < y1c) begin
                state <= ST_FILL;
              end else begin
                state   <= ST_IDLE;
                done    <= 1'b1;
                pixel_q <= COLOR_BLANK;
              end
            end
            OP_CLEAR: begin
              clr_cnt <= '0;
              state   <= ST_CLEAR;
            end
            OP_READ: begin
              state <= ST_READ;
            end
            default: begin
              state   <= ST_IDLE;
              done    <= 1'b1;
              pixel_q <= COLOR_BLANK;
            end
          endcase
        end
        ST_FILL: begin
          // advance along the row, then to the next row
          if (x_cnt + XCW'(1) == x1) begin
            x_cnt <= x0;
            if (y_cnt + YCW'(1) == y1) begin
              state <= ST_DRAIN;
            end else begin
              y_cnt <= y_cnt + YCW'(1);
            end
          end else begin
            x_cnt <= x_cnt + XCW'(1);
          end
        end
        ST_DRAIN: begin
          if (!rd_valid && !bl_active) begin
            state   <= ST_IDLE;
            done    <= 1'b1;
            pixel_q <= COLOR_BLANK;
          end
        end
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + ADDR_W'(1);
          if (&clr_cnt) begin
            state   <= ST_IDLE;
            done    <= 1'b1;
            pixel_q <= COLOR_BLANK;
          end
        end
        ST_READ: begin
          state   <= ST_IDLE;
          done    <= 1'b1;
          pixel_q <= in_bounds_q ? rd_data : COLOR_BLANK;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Hold the command fields and the clipped rectangle
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      op_q     <= operation;
      left_q   <= left;
      top_q    <= top;
      right_q  <= right;
      bottom_q <= bottom;
      color_q  <= '{red: red, green: green, blue: blue, alpha: alpha};
    end
    if (state == ST_SETUP) begin
      x0          <= x0c;
      x1          <= x1c;
      y1          <= y1c;
      in_bounds_q <= in_bounds;
    end
  end

  rfab_store #(
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rfab_blend #(
    .ADDR_W (ADDR_W)
  ) u_blend (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rd_valid),
    .in_addr   (rd_addr_q),
    .dst       (rd_data),
    .src       (color_q),
    .out_valid (bl_valid),
    .out_addr  (bl_addr),
    .out_pixel (bl_pixel),
    .active    (bl_active)
  );

  assign busy        = (state != ST_IDLE);
  assign pixel_red   = pixel_q.red;
  assign pixel_green = pixel_q.green;
  assign pixel_blue  = pixel_q.blue;
  assign pixel_alpha = pixel_q.alpha;

endmodule

### rtl/rfab_check.sv
// ----------------------------------------------------------------------------
// rfab_check: port-level checks for the rectangle fill blender
// Command and result beat ordering seen on the top level ports.
// ----------------------------------------------------------------------------
module rfab_check (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // A result beat lasts exactly one cycle
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held longer than one cycle");

  // A result beat only follows a command in progress
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("done without a command in progress");

  // The block is free again when its result is shown
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while still busy");

  // An accepted command makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("command accepted but block not busy");

endmodule

bind rect_fill_alpha_blend_top rfab_check u_rfab_check (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

### test/rect_fill_alpha_blend_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rect_fill_alpha_blend_top_tb: self-checking bench for the rectangle blender
// Drives fill, clear, read and unused commands through the start/busy port.
// A local copy of the pixel store and canvas registers predicts each readback
// beat. The run moves through a range of canvas sizes, from empty to oversize.
// ----------------------------------------------------------------------------
module rect_fill_alpha_blend_top_tb;
  import rfab_pkg::*;

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 10;
  localparam int STORE_DEPTH    = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
  localparam int OPAQUE         = 255;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 270000;
  localparam int RANDOM_CLEARS  = 3;
  localparam int ITEMS_PER_SET  = 46;
  localparam int NUM_SETS       = 12;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [OP_W-1:0]           op;
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] top;
    logic signed [COORD_W-1:0] right;
    logic signed [COORD_W-1:0] bottom;
    color_t                    color;
  } canvas_cmd_t;

  // DUT ports
  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0]       cfg_data = '0;
  logic                   start = 1'b0;
  logic [OP_W-1:0]        operation = '0;
  logic [COORD_W-1:0]     left = '0;
  logic [COORD_W-1:0]     top = '0;
  logic [COORD_W-1:0]     right = '0;
  logic [COORD_W-1:0]     bottom = '0;
  logic [CHAN_W-1:0]      red = '0;
  logic [CHAN_W-1:0]      green = '0;
  logic [CHAN_W-1:0]      blue = '0;
  logic [CHAN_W-1:0]      alpha = '0;
  logic                   busy;
  logic                   done;
  logic [CHAN_W-1:0]      pixel_red;
  logic [CHAN_W-1:0]      pixel_green;
  logic [CHAN_W-1:0]      pixel_blue;
  logic [CHAN_W-1:0]      pixel_alpha;

  // Predicted canvas state
  color_t           canvas_px [0:STORE_DEPTH-1];
  logic [REG_W-1:0] canvas_w_reg = REG_W'(CANVAS_RESET);
  logic [REG_W-1:0] canvas_h_reg = REG_W'(CANVAS_RESET);

  canvas_cmd_t pending_cmds [$];
  color_t      readback_q [$];
  canvas_cmd_t cur_cmd;

  int gap_left = 0;
  int quiet_run = 0;
  int clears_left = RANDOM_CLEARS;
  int last_x = 0;
  int last_y = 0;
  int errors = 0;
  int beats_checked = 0;
  int op_seen [4] = '{0, 0, 0, 0};
  int settings_run = 0;
  int idle_cycles = 0;

  // Canvas sizes for the random sets
  int set_w [NUM_SETS] = '{16, 0, 1, 256, 511, 5, 200, 256, 1, 33, 300, 16};
  int set_h [NUM_SETS] = '{16, 0, 1, 256, 511, 200, 5, 1, 256, 17, 9, 16};

  rect_fill_alpha_blend_top uut (.*);

  initial begin
    forever #(CLK_HALF) clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Predictor
  // -------------------------------------------------------------------------
  function automatic int clamp_to(int v, int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int eff_span(logic [REG_W-1:0] reg_val, int max_span);
    return (int'(reg_val) > max_span) ? max_span : int'(reg_val);
  endfunction

  function automatic logic [CHAN_W-1:0] over_chan(int unsigned s, int unsigned d,
                                                  int unsigned a);
    int unsigned mixed;
    mixed = s * a + d * (OPAQUE - a);
    return CHAN_W'((2 * mixed + OPAQUE) / (2 * OPAQUE));
  endfunction

  // Straight-alpha over: opaque replaces, transparent keeps
  function automatic color_t blend_px(color_t dst, color_t src);
    color_t      o;
    int unsigned a;
    int unsigned oa;
    a = src.alpha;
    if (a == OPAQUE) return src;
    if (a == 0) return dst;
    o.red   = over_chan(src.red, dst.red, a);
    o.green = over_chan(src.green, dst.green, a);
    o.blue  = over_chan(src.blue, dst.blue, a);
    oa = a + (2 * dst.alpha * (OPAQUE - a) + OPAQUE) / (2 * OPAQUE);
    o.alpha = (oa > OPAQUE) ? CHAN_W'(OPAQUE) : oa[CHAN_W-1:0];
    return o;
  endfunction

  // Apply one command to the predicted canvas, return the expected readback
  function automatic color_t run_canvas_cmd(canvas_cmd_t c);
    int     ew;
    int     eh;
    int     x0;
    int     x1;
    int     y0;
    int     y1;
    int     cx;
    int     cy;
    color_t px;
    ew = eff_span(canvas_w_reg, DEF_MAX_WIDTH);
    eh = eff_span(canvas_h_reg, DEF_MAX_HEIGHT);
    px = COLOR_BLANK;
    case (c.op)
      OP_FILL: begin
        x0 = clamp_to(c.left, ew);
        x1 = clamp_to(c.right, ew);
        y0 = clamp_to(c.top, eh);
        y1 = clamp_to(c.bottom, eh);
        for (int y = y0; y < y1; y++) begin
          for (int x = x0; x < x1; x++) begin
            canvas_px[y * DEF_MAX_WIDTH + x] =
              blend_px(canvas_px[y * DEF_MAX_WIDTH + x], c.color);
          end
        end
      end
      OP_CLEAR: begin
        foreach (canvas_px[i]) canvas_px[i] = c.color;
      end
      OP_READ: begin
        cx = c.left;
        cy = c.top;
        if (cx >= 0 && cy >= 0 && cx < ew && cy < eh) begin
          px = canvas_px[cy * DEF_MAX_WIDTH + cx];
        end
      end
      default: ;
    endcase
    return px;
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------
  task automatic queue_cmd(logic [OP_W-1:0] op, int l, int t, int r, int b,
                           color_t col);
    canvas_cmd_t c;
    c.op     = op;
    c.left   = l[COORD_W-1:0];
    c.top    = t[COORD_W-1:0];
    c.right  = r[COORD_W-1:0];
    c.bottom = b[COORD_W-1:0];
    c.color  = col;
    pending_cmds = {pending_cmds, c};
  endtask

  // Mostly fill-then-read sequences near the canvas, some wild coordinates
  function automatic canvas_cmd_t pick_random_cmd();
    canvas_cmd_t c;
    int          ew;
    int          eh;
    int          roll;
    int          x;
    int          y;
    ew = eff_span(canvas_w_reg, DEF_MAX_WIDTH);
    eh = eff_span(canvas_h_reg, DEF_MAX_HEIGHT);
    c.color  = color_t'($urandom);
    c.left   = COORD_W'($urandom);
    c.top    = COORD_W'($urandom);
    c.right  = COORD_W'($urandom);
    c.bottom = COORD_W'($urandom);
    case ($urandom_range(0, 5))
      0: c.color.alpha = '0;
      1: c.color.alpha = CHAN_W'(OPAQUE);
      default: ;
    endcase
    roll = $urandom_range(0, 99);
    if (roll < 45) begin
      c.op = OP_FILL;
      // full-range edges only where the clipped area stays cheap
      if (!(ew <= 32 && eh <= 32 && $urandom_range(0, 7) == 0)) begin
        x = $urandom_range(0, ew + 7) - 4;
        y = $urandom_range(0, eh + 7) - 4;
        c.left   = x[COORD_W-1:0];
        c.top    = y[COORD_W-1:0];
        c.right  = COORD_W'(x + $urandom_range(0, 9) - 1);
        c.bottom = COORD_W'(y + $urandom_range(0, 9) - 1);
        last_x = x;
        last_y = y;
      end
    end else if (roll < 85) begin
      c.op = OP_READ;
      if ($urandom_range(0, 2) != 0) begin
        x = last_x + $urandom_range(0, 7) - 1;
        y = last_y + $urandom_range(0, 7) - 1;
      end else begin
        x = $urandom_range(0, ew + 3) - 2;
        y = $urandom_range(0, eh + 3) - 2;
      end
      c.left = x[COORD_W-1:0];
      c.top  = y[COORD_W-1:0];
    end else if (roll < 93) begin
      c.op = OP_READ;
    end else if (roll < 97) begin
      c.op = OP_UNUSED;
    end else if (clears_left > 0) begin
      c.op = OP_CLEAR;
      clears_left--;
    end else begin
      c.op = OP_READ;
    end
    return c;
  endfunction

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [REG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_CANVAS_WIDTH) canvas_w_reg = val;
    else canvas_h_reg = val;
  endtask

  // Wait until every command is taken, answered and the block is idle
  task automatic wait_drained();
    @(negedge clk);
    while (pending_cmds.size() != 0 || start || readback_q.size() != 0 || busy)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic check_chan(string chan, logic [CHAN_W-1:0] want,
                            logic [CHAN_W-1:0] got);
    if (got !== want) begin
      $display("%0t ERROR: %s mismatch, expected %0d, actual %0d", $time, chan,
               want, got);
      errors++;
    end
  endtask

  // -------------------------------------------------------------------------
  // Driver: one command per beat, random gap after each accepted beat
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        readback_q = {readback_q, run_canvas_cmd(cur_cmd)};
        op_seen[cur_cmd.op]++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          cur_cmd = pending_cmds.pop_front();
          operation <= cur_cmd.op;
          left      <= cur_cmd.left;
          top       <= cur_cmd.top;
          right     <= cur_cmd.right;
          bottom    <= cur_cmd.bottom;
          red       <= cur_cmd.color.red;
          green     <= cur_cmd.color.green;
          blue      <= cur_cmd.color.blue;
          alpha     <= cur_cmd.color.alpha;
          start     <= 1'b1;
          // back-to-back stretches between random gaps
          if (quiet_run > 0) begin
            quiet_run--;
            gap_left = 0;
          end else if ($urandom_range(0, 9) == 0) begin
            quiet_run = $urandom_range(4, 16);
            gap_left = 0;
          end else begin
            gap_left = $urandom_range(0, 4);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Monitor: compare each result beat with the oldest prediction
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    color_t want;
    if (!rst && done) begin
      if (readback_q.size() == 0) begin
        $display("%0t ERROR: unexpected result beat, expected none, actual %h%h%h%h",
                 $time, pixel_red, pixel_green, pixel_blue, pixel_alpha);
        errors++;
      end else begin
        want = readback_q.pop_front();
        beats_checked++;
        check_chan("pixel_red", want.red, pixel_red);
        check_chan("pixel_green", want.green, pixel_green);
        check_chan("pixel_blue", want.blue, pixel_blue);
        check_chan("pixel_alpha", want.alpha, pixel_alpha);
      end
    end
  end

  // Watchdog: count cycles with no beat in either direction
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ERROR: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    foreach (canvas_px[i]) canvas_px[i] = COLOR_BLANK;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed: store after reset, opaque and transparent, partial blends
    queue_cmd(OP_READ, 0, 0, 0, 0, 32'h0);
    queue_cmd(OP_READ, 255, 255, 0, 0, 32'hFFFF_FFFF);
    queue_cmd(OP_FILL, 3, 4, 4, 5, {8'd10, 8'd20, 8'd30, 8'd255});
    queue_cmd(OP_READ, 3, 4, 0, 0, 32'h0);
    queue_cmd(OP_FILL, 3, 4, 4, 5, {8'd200, 8'd200, 8'd200, 8'd0});
    queue_cmd(OP_READ, 3, 4, 0, 0, 32'h0);
    queue_cmd(OP_FILL, 3, 4, 5, 6, {8'd255, 8'd0, 8'd128, 8'd128});
    queue_cmd(OP_READ, 3, 4, 0, 0, 32'h0);
    queue_cmd(OP_FILL, 3, 4, 5, 6, {8'd0, 8'd255, 8'd255, 8'd1});
    queue_cmd(OP_FILL, 3, 4, 5, 6, {8'd77, 8'd1, 8'd254, 8'd254});
    queue_cmd(OP_READ, 4, 5, 0, 0, 32'h0);
    // inverted and empty rectangles leave pixels alone
    queue_cmd(OP_FILL, 20, 20, 10, 10, 32'hFFFF_FFFF);
    queue_cmd(OP_READ, 15, 15, 0, 0, 32'h0);
    queue_cmd(OP_FILL, 30, 30, 30, 40, 32'hFFFF_FFFF);
    queue_cmd(OP_READ, 30, 30, 0, 0, 32'h0);
    // reads off the canvas return blank
    queue_cmd(OP_READ, -1, 0, 0, 0, 32'h0);
    queue_cmd(OP_READ, 0, 256, 0, 0, 32'h0);
    queue_cmd(OP_READ, -32768, 32767, 0, 0, 32'h0);
    queue_cmd(OP_READ, 32767, -1, 0, 0, 32'h0);
    // unused code touches nothing
    queue_cmd(OP_UNUSED, -32768, 32767, -1, 0, 32'hFFFF_FFFF);
    queue_cmd(OP_READ, 3, 4, 0, 0, 32'h0);
    // full-range rectangle clips to the whole canvas
    queue_cmd(OP_FILL, -32768, -32768, 32767, 32767, {8'd40, 8'd80, 8'd160, 8'd100});
    queue_cmd(OP_READ, 255, 255, 0, 0, 32'h0);
    // clear ignores the rectangle fields
    queue_cmd(OP_CLEAR, 7, 7, 1, 1, {8'h12, 8'h34, 8'h56, 8'h78});
    queue_cmd(OP_READ, 0, 0, 0, 0, 32'h0);
    queue_cmd(OP_READ, 255, 255, 0, 0, 32'h0);
    wait_drained();

    // Random sets, each under its own canvas size
    for (int s = 0; s < NUM_SETS; s++) begin
      write_reg(CFG_CANVAS_WIDTH, set_w[s][REG_W-1:0]);
      write_reg(CFG_CANVAS_HEIGHT, set_h[s][REG_W-1:0]);
      settings_run++;
      repeat (ITEMS_PER_SET) pending_cmds = {pending_cmds, pick_random_cmd()};
      wait_drained();
    end

    $display("Ran %0d commands: %0d fill, %0d clear, %0d read, %0d unused code",
             op_seen[OP_FILL] + op_seen[OP_CLEAR] + op_seen[OP_READ] + op_seen[OP_UNUSED],
             op_seen[OP_FILL], op_seen[OP_CLEAR], op_seen[OP_READ], op_seen[OP_UNUSED]);
    $display("Checked %0d result beats across %0d canvas sizes, %0d errors",
             beats_checked, settings_run + 1, errors);
    if (errors == 0 && readback_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
